FILE: rtl/alb_pkg.sv
// ----------------------------------------------------------------------------
// Alarm LED blink package
// Shared types, register indexes and constants for the alarm LED blinker.
// ----------------------------------------------------------------------------
package alb_pkg;

  localparam int unsigned FlagW    = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned PhaseW   = 5;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 4;

  localparam logic [PhaseW-1:0] PhaseLast   = PhaseW'(19);
  localparam logic [CountW-1:0] CountSat    = '1;
  localparam logic [FlagW-1:0]  FlagsNone   = 8'hFF;

  localparam logic [FlagW-1:0]  TempMaskRst  = 8'd1;
  localparam logic [FlagW-1:0]  HumidMaskRst = 8'd2;
  localparam logic [FlagW-1:0]  LightMaskRst = 8'd4;
  localparam logic [CountW-1:0] HystRst      = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_MASK  = 4'd0,
    CFG_HUMID_MASK = 4'd1,
    CFG_LIGHT_MASK = 4'd2,
    CFG_HYST_TICKS = 4'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_FAST   = 3'd1,
    MODE_SLOW   = 3'd2,
    MODE_DOUBLE = 3'd3,
    MODE_SOLID  = 3'd4
  } led_pattern_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ALARM = 2'd1,
    EV_CLEAR = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [FlagW-1:0]  temp_mask;
    logic [FlagW-1:0]  humid_mask;
    logic [FlagW-1:0]  light_mask;
    logic [CountW-1:0] hyst_ticks;
  } alb_cfg_t;

  typedef struct packed {
    logic              led_on;
    led_pattern_e      pattern;
    event_kind_e       event_kind;
    logic [FlagW-1:0]  event_flags;
    logic [TimeW-1:0]  event_time;
  } alb_result_t;

endpackage

FILE: rtl/alb_cfg_regs.sv
// ----------------------------------------------------------------------------
// Alarm LED blink configuration registers
// Holds the three alarm masks and the hysteresis threshold.
// ----------------------------------------------------------------------------
module alb_cfg_regs import alb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [FlagW-1:0]   cfg_data_i,
  output alb_cfg_t           cfg_o
);

  alb_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TEMP_MASK:  cfg_d.temp_mask  = cfg_data_i;
        CFG_HUMID_MASK: cfg_d.humid_mask = cfg_data_i;
        CFG_LIGHT_MASK: cfg_d.light_mask = cfg_data_i;
        CFG_HYST_TICKS: cfg_d.hyst_ticks = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_mask  <= TempMaskRst;
      cfg_q.humid_mask <= HumidMaskRst;
      cfg_q.light_mask <= LightMaskRst;
      cfg_q.hyst_ticks <= HystRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/alb_core.sv
// ----------------------------------------------------------------------------
// Alarm LED blink core
// Tick state (phase, tick count, hysteresis counters, accepted flags) and
// the single-pass logic that turns one flag byte into one result.
// ----------------------------------------------------------------------------
module alb_core import alb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [FlagW-1:0] flags_i,
  input  alb_cfg_t         cfg_i,
  output alb_result_t      result_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TimeW-1:0]  ticks_q, ticks_d;
  logic [CountW-1:0] confirm_q, confirm_d;
  logic [CountW-1:0] clear_q, clear_d;
  logic [FlagW-1:0]  accepted_q, accepted_d;

  logic         hit_t, hit_h, hit_l;
  logic [1:0]   hits;
  led_pattern_e mode;
  logic         led;
  logic         nonzero;
  logic         take_alarm, take_clear;

  always_comb begin
    hit_t = |(flags_i & cfg_i.temp_mask);
    hit_h = |(flags_i & cfg_i.humid_mask);
    hit_l = |(flags_i & cfg_i.light_mask);
    hits  = 2'(hit_t) + 2'(hit_h) + 2'(hit_l);

    if (hits == 2'd0)      mode = MODE_OFF;
    else if (hits >= 2'd2) mode = MODE_SOLID;
    else if (hit_t)        mode = MODE_FAST;
    else if (hit_h)        mode = MODE_SLOW;
    else                   mode = MODE_DOUBLE;

    case (mode)
      MODE_FAST:   led = ~phase_q[0];
      // Lit for the first half of each ten-tick half period.
      MODE_SLOW:   led = (phase_q < PhaseW'(5)) ||
                         ((phase_q >= PhaseW'(10)) && (phase_q < PhaseW'(15)));
      MODE_DOUBLE: led = (phase_q < PhaseW'(2)) ||
                         ((phase_q >= PhaseW'(4)) && (phase_q < PhaseW'(6)));
      MODE_SOLID:  led = 1'b1;
      default:     led = 1'b0;
    endcase
  end

  always_comb begin
    nonzero = |flags_i;
    if (nonzero) begin
      confirm_d = (confirm_q == CountSat) ? confirm_q : confirm_q + CountW'(1);
      clear_d   = '0;
    end else begin
      clear_d   = (clear_q == CountSat) ? clear_q : clear_q + CountW'(1);
      confirm_d = '0;
    end

    // A threshold of zero is met on the first tick, same as one.
    take_alarm = (flags_i != accepted_q) && nonzero && (confirm_d >= cfg_i.hyst_ticks);
    take_clear = (flags_i != accepted_q) && !nonzero && (clear_d >= cfg_i.hyst_ticks);

    accepted_d = accepted_q;
    if (take_alarm)      accepted_d = flags_i;
    else if (take_clear) accepted_d = '0;

    ticks_d = ticks_q + TimeW'(1);
    phase_d = (phase_q == PhaseLast) ? '0 : phase_q + PhaseW'(1);

    result_o.led_on      = led;
    result_o.pattern     = mode;
    result_o.event_kind  = take_alarm ? EV_ALARM : (take_clear ? EV_CLEAR : EV_NONE);
    result_o.event_flags = take_alarm ? flags_i : '0;
    result_o.event_time  = (take_alarm || take_clear) ? ticks_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      ticks_q    <= '0;
      confirm_q  <= '0;
      clear_q    <= '0;
      accepted_q <= FlagsNone;
    end else if (step_i) begin
      phase_q    <= phase_d;
      ticks_q    <= ticks_d;
      confirm_q  <= confirm_d;
      clear_q    <= clear_d;
      accepted_q <= accepted_d;
    end
  end

endmodule

FILE: rtl/alarm_led_blink_with_hysteresis.sv
// ----------------------------------------------------------------------------
// Alarm LED blink with hysteresis
// One period tick per input transaction: blink mode, LED level and
// hysteresis-filtered alarm and clear events.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid_i/in_stall_o  alarm_flags_i
//  out      output     out_valid_o/out_stall_i led_on_o, pattern_o,
//                                             event_kind_o, event_flags_o,
//                                             event_time_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  A tick is captured in the input register, passes the core logic and lands
//  in the result register, which drives the output.
//  One transaction per cycle is sustained while the output does not stall;
//  the limit is the single result register, which refills in the cycle it
//  is emptied.
//  Reset clears the counters and loads the accepted-flag and register resets.
//  An output stall holds full result and input registers, stalling the input.
// ----------------------------------------------------------------------------
module alarm_led_blink_with_hysteresis import alb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FlagW-1:0]   alarm_flags_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               led_on_o,
  output logic [2:0]         pattern_o,
  output logic [1:0]         event_kind_o,
  output logic [FlagW-1:0]   event_flags_o,
  output logic [TimeW-1:0]   event_time_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [FlagW-1:0]   cfg_data_i
);

  alb_cfg_t    cfg;
  alb_result_t core_res;
  alb_result_t res_q;

  logic             in_vld_q;
  logic [FlagW-1:0] flags_q;
  logic             out_vld_q;
  logic             out_adv;
  logic             step;
  logic             in_take;

  alb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The result register can load when it is empty or being emptied.
  assign out_adv    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_adv;
  assign in_stall_o = in_vld_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  alb_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .flags_i  (flags_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (out_adv)     out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) flags_q <= alarm_flags_i;
    if (step)    res_q   <= core_res;
  end

  assign out_valid_o   = out_vld_q;
  assign led_on_o      = res_q.led_on;
  assign pattern_o     = res_q.pattern;
  assign event_kind_o  = res_q.event_kind;
  assign event_flags_o = res_q.event_flags;
  assign event_time_o  = res_q.event_time;

  a_no_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.event_kind == EV_NONE) |->
      (res_q.event_flags == '0) && (res_q.event_time == '0))
    else $error("payload set without an event");

  a_solid_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.pattern == MODE_SOLID) |-> res_q.led_on)
    else $error("solid mode with LED dark");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.pattern == MODE_OFF) |-> !res_q.led_on)
    else $error("off mode with LED lit");

  a_clear_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.event_kind == EV_CLEAR) |-> (res_q.event_flags == '0))
    else $error("clear event carries flags");

  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("processed tick lost before result register");

endmodule

FILE: sim/alarm_led_blink_with_hysteresis_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm LED blink with hysteresis testbench
// Drives alarm flag ticks through the blinker under random back-pressure and
// predicts each result: blink mode, LED level from the phase counter, and the
// alarm and clear events that the hysteresis counters confirm. The masks and
// the hysteresis are reprogrammed between phases, extreme values included.
// ----------------------------------------------------------------------------
module alarm_led_blink_with_hysteresis_tb;
  import alb_pkg::*;

  localparam int unsigned LongHoldCycles = 80;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [FlagW-1:0]   alarm_flags_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               led_on_o;
  logic [2:0]         pattern_o;
  logic [1:0]         event_kind_o;
  logic [FlagW-1:0]   event_flags_o;
  logic [TimeW-1:0]   event_time_o;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [FlagW-1:0]   cfg_data_i    = '0;

  alarm_led_blink_with_hysteresis DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .alarm_flags_i (alarm_flags_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .led_on_o      (led_on_o),
    .pattern_o     (pattern_o),
    .event_kind_o  (event_kind_o),
    .event_flags_o (event_flags_o),
    .event_time_o  (event_time_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted block state and register copies.
  logic [FlagW-1:0]  mask_temp   = TempMaskRst;
  logic [FlagW-1:0]  mask_humid  = HumidMaskRst;
  logic [FlagW-1:0]  mask_light  = LightMaskRst;
  logic [CountW-1:0] hyst        = HystRst;
  logic [PhaseW-1:0] phase_q     = '0;
  logic [TimeW-1:0]  ticks_q     = '0;
  logic [CountW-1:0] nz_run      = '0;
  logic [CountW-1:0] zero_run    = '0;
  logic [FlagW-1:0]  taken_flags = FlagsNone;

  logic [FlagW-1:0] flag_backlog [$];
  alb_result_t      expected_ticks [$];
  alb_result_t      due;

  logic idle_en      = 1'b1;
  logic src_hold     = 1'b0;
  logic long_hold_on = 1'b0;
  int   src_gap      = 0;
  int   sink_burst   = 0;
  int   hold_cycles  = 0;
  int   err_count    = 0;
  int   n_ticks      = 0;
  int   n_alarm      = 0;
  int   n_clear      = 0;
  int   n_stalled_in = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic alb_result_t blink_tick(logic [FlagW-1:0] f);
    alb_result_t  r;
    logic         t, h, l;
    int           hits;
    led_pattern_e m;
    t    = |(f & mask_temp);
    h    = |(f & mask_humid);
    l    = |(f & mask_light);
    hits = int'(t) + int'(h) + int'(l);
    if (hits == 0)      m = MODE_OFF;
    else if (hits >= 2) m = MODE_SOLID;
    else if (t)         m = MODE_FAST;
    else if (h)         m = MODE_SLOW;
    else                m = MODE_DOUBLE;
    r = '0;
    r.pattern = m;
    case (m)
      MODE_FAST:   r.led_on = ~phase_q[0];
      MODE_SLOW:   r.led_on = (phase_q % 10) < 5;
      MODE_DOUBLE: r.led_on = (phase_q < 2) || (phase_q >= 4 && phase_q < 6);
      MODE_SOLID:  r.led_on = 1'b1;
      default:     r.led_on = 1'b0;
    endcase
    if (f != '0) begin
      if (nz_run != CountSat) nz_run++;
      zero_run = '0;
    end else begin
      if (zero_run != CountSat) zero_run++;
      nz_run = '0;
    end
    // A zero threshold behaves like one since the run count is already at least one.
    if (f != taken_flags) begin
      if (f != '0 && nz_run >= hyst) begin
        r.event_kind  = EV_ALARM;
        r.event_flags = f;
        r.event_time  = ticks_q;
        taken_flags   = f;
        n_alarm++;
      end else if (f == '0 && zero_run >= hyst) begin
        r.event_kind  = EV_CLEAR;
        r.event_time  = ticks_q;
        taken_flags   = '0;
        n_clear++;
      end
    end
    ticks_q++;
    phase_q = (phase_q == PhaseLast) ? '0 : phase_q + 1'b1;
    return r;
  endfunction

  // Sender: holds the transaction while stalled, otherwise refills or idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_ticks.push_back(blink_tick(alarm_flags_i));
        n_ticks++;
      end
      if (in_valid_i && in_stall_o) n_stalled_in++;
      if (!in_valid_i || !in_stall_o) begin
        if (src_gap != 0) begin
          src_gap    <= src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (flag_backlog.size() != 0 && !src_hold) begin
          if (idle_en && $urandom_range(0, 9) == 0) begin
            src_gap    <= $urandom_range(0, 4);
            in_valid_i <= 1'b0;
          end else begin
            in_valid_i    <= 1'b1;
            alarm_flags_i <= flag_backlog.pop_front();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every transaction and applies random or long stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_burst  <= 0;
      hold_cycles <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_ticks.size() == 0) begin
          $error("result with no tick outstanding");
          err_count++;
        end else begin
          due = expected_ticks.pop_front();
          if (led_on_o !== due.led_on) begin
            $error("led_on: expected %0d, actual %0d", due.led_on, led_on_o);
            err_count++;
          end
          if (pattern_o !== due.pattern) begin
            $error("pattern: expected %0d, actual %0d", due.pattern, pattern_o);
            err_count++;
          end
          if (event_kind_o !== due.event_kind) begin
            $error("event_kind: expected %0d, actual %0d", due.event_kind, event_kind_o);
            err_count++;
          end
          if (event_flags_o !== due.event_flags) begin
            $error("event_flags: expected %0d, actual %0d", due.event_flags, event_flags_o);
            err_count++;
          end
          if (event_time_o !== due.event_time) begin
            $error("event_time: expected %0d, actual %0d", due.event_time, event_time_o);
            err_count++;
          end
        end
      end
      if (long_hold_on && hold_cycles < LongHoldCycles) begin
        hold_cycles <= hold_cycles + 1;
        out_stall_i <= 1'b1;
      end else if (sink_burst != 0) begin
        sink_burst  <= sink_burst - 1;
        out_stall_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        sink_burst  <= $urandom_range(0, 4);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      if (!long_hold_on) hold_cycles <= 0;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (flag_backlog.size() != 0 || in_valid_i || expected_ticks.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [FlagW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TEMP_MASK:  mask_temp  = val;
      CFG_HUMID_MASK: mask_humid = val;
      CFG_LIGHT_MASK: mask_light = val;
      CFG_HYST_TICKS: hyst       = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [FlagW-1:0] t, logic [FlagW-1:0] h, logic [FlagW-1:0] l,
                          logic [CountW-1:0] n);
    write_reg(CFG_TEMP_MASK, t);
    write_reg(CFG_HUMID_MASK, h);
    write_reg(CFG_LIGHT_MASK, l);
    write_reg(CFG_HYST_TICKS, n);
  endtask

  task automatic push_repeat(logic [FlagW-1:0] f, int n);
    repeat (n) flag_backlog.push_back(f);
  endtask

  // Mostly runs long enough to pass the threshold, with short glitches mixed in.
  task automatic queue_runs(int n, int lo);
    int               cnt;
    int               len;
    int               sel;
    logic [FlagW-1:0] f;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)       f = '0;
      else if (sel == 4) f = 8'hFF;
      else               f = FlagW'($urandom);
      if ($urandom_range(0, 4) == 0) len = 1;
      else                           len = $urandom_range(lo, lo + 4);
      repeat (len) begin
        if ($urandom_range(0, 14) == 0) flag_backlog.push_back(FlagW'($urandom));
        else                            flag_backlog.push_back(f);
        cnt++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks under the reset settings. An all-ones byte matches the
    // initial accepted value, so it must not raise an alarm on its own.
    push_repeat(8'hFF, 6);
    push_repeat(8'h00, 5);
    push_repeat(8'h01, 5);
    flag_backlog.push_back(8'h02);
    flag_backlog.push_back(8'h04);
    flag_backlog.push_back(8'h06);
    flag_backlog.push_back(8'h08);
    flag_backlog.push_back(8'h80);
    flag_backlog.push_back(8'h07);
    push_repeat(8'h00, 3);
    wait_drained();

    // Overlapping masks with a zero threshold.
    set_regs(8'h0F, 8'h3C, 8'hF0, 8'd0);
    queue_runs(150, 1);
    wait_drained();

    // No mask hits at all: the LED stays dark while events still come.
    set_regs(8'h00, 8'h00, 8'h00, 8'd1);
    queue_runs(100, 1);
    wait_drained();

    // Largest threshold: runs long enough to saturate both counters.
    set_regs(8'hFF, 8'hFF, 8'hFF, 8'd255);
    push_repeat(8'h5A, 270);
    push_repeat(8'h00, 270);
    wait_drained();

    // Long output stall while the sender keeps offering ticks.
    set_regs(8'h01, 8'h02, 8'h04, 8'd3);
    long_hold_on = 1'b1;
    queue_runs(150, 3);
    wait_drained();
    long_hold_on = 1'b0;

    repeat (3) begin
      set_regs(FlagW'($urandom), FlagW'($urandom), FlagW'($urandom),
               CountW'($urandom_range(1, 6)));
      queue_runs(110, int'(hyst));
      wait_drained();
      queue_runs(110, int'(hyst));
      wait_drained();
    end

    // Final stretch at full rate on both sides.
    idle_en = 1'b0;
    set_regs(8'h11, 8'h22, 8'hC4, 8'd2);
    queue_runs(200, 2);
    wait_drained();
    repeat (10) @(negedge clk_i);

    $display("Checked %0d ticks: %0d alarm and %0d clear events, %0d input stall cycles.",
             n_ticks, n_alarm, n_clear, n_stalled_in);
    $display("Masks and thresholds swept from zero to all ones, with long output stalls.");
    if (err_count == 0) begin
      $display("[alarm_led_blink_with_hysteresis] OK");
    end else begin
      $display("[alarm_led_blink_with_hysteresis] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[alarm_led_blink_with_hysteresis] ERROR");
    $finish;
  end

endmodule
